@@ src/global_history_branch_predictor_core_assert.svh @@
// assertion macros used by the predictor checker
// expects clk and rst_n in the scope where a macro is used
`ifndef GLOBAL_HISTORY_BRANCH_PREDICTOR_CORE_ASSERT_SVH
`define GLOBAL_HISTORY_BRANCH_PREDICTOR_CORE_ASSERT_SVH

// antecedent implies consequent, consequent may carry a fixed delay
`define GHBP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("predictor check failed");

// condition holds at every clock edge outside reset
`define GHBP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("predictor invariant failed");

`endif

@@ src/ghbp_pkg.sv @@
// shared types and constants of the global-history branch predictor
// no dependencies
`default_nettype none

package ghbp_pkg;

  localparam int PC_W   = 64;
  localparam int TAG_W  = 16;
  localparam int HIST_W = 16;
  localparam int CTR_W  = 2;

  localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'b10;
  localparam logic [CTR_W-1:0] CTR_MAX        = 2'b11;
  localparam logic [CTR_W-1:0] CTR_MIN        = 2'b00;

  localparam logic [PC_W-1:0] FALL_STEP = 64'd4;

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_UPDATE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_FETCH
  } state_t;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [PC_W-1:0]  addr_t;
  typedef logic [CTR_W-1:0] ctr_t;

endpackage

`default_nettype wire

@@ src/global_history_branch_predictor_core.sv @@
// global-history branch predictor with a fifo-filled branch target buffer
// depends on ghbp_pkg
`default_nettype none

// Usage: an item is taken when start is high and busy is low. After reset the
// block sweeps the counter memory to weakly taken, one entry a cycle, and holds
// busy high until the sweep ends. An update item keeps busy high while the
// block is in S_LOOK after it is taken. A predict item keeps busy high through
// S_LOOK and S_FETCH, and its word appears on out_predicted_target with out_valid
// high for exactly one cycle, from a register loaded in S_FETCH; a new item may
// be taken in that same cycle. These states come from the registered read of the
// counter memory followed by the encode of the target-buffer tag match and the
// registered read of the destination memory.
// The receiver cannot stall: a word not taken in its strobe cycle is gone.
module global_history_branch_predictor_core #(
  parameter int COUNTER_ENTRIES = 2048,
  parameter int BUFFER_ENTRIES  = 128
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire                            in_operation,
  input  wire  [ghbp_pkg::PC_W-1:0]      in_pc,
  input  wire  [ghbp_pkg::PC_W-1:0]      in_actual_target,
  output logic                           out_valid,
  output logic [ghbp_pkg::PC_W-1:0]      out_predicted_target
);

  localparam int CIDX_W    = $clog2(COUNTER_ENTRIES);
  localparam int BIDX_W    = $clog2(BUFFER_ENTRIES);
  localparam int SUM_W     = CIDX_W + 2;
  localparam int HIST_WRAP = (1 << ghbp_pkg::HIST_W) % COUNTER_ENTRIES;

  localparam logic [SUM_W-1:0]  ENTRIES_S = SUM_W'(COUNTER_ENTRIES);
  localparam logic [SUM_W-1:0]  WRAP_S    = SUM_W'(HIST_WRAP);
  localparam logic [CIDX_W-1:0] CLR_LAST  = CIDX_W'(COUNTER_ENTRIES - 1);
  localparam logic [BIDX_W-1:0] PTR_LAST  = BIDX_W'(BUFFER_ENTRIES - 1);

  ghbp_pkg::state_t state_r, state_nxt;

  logic [CIDX_W-1:0]           clr_r, clr_nxt;
  logic [CIDX_W-1:0]           idx_r, idx_nxt;
  logic [ghbp_pkg::HIST_W-1:0] hist_r, hist_nxt;
  logic [BIDX_W-1:0]           ptr_r, ptr_nxt;

  logic                  op_r;
  ghbp_pkg::addr_t       pc_r;
  ghbp_pkg::addr_t       tgt_r;
  logic [BUFFER_ENTRIES-1:0] hit_vec_r;
  ghbp_pkg::ctr_t        ctr_rd_r;
  ghbp_pkg::tag_t        dest_rd_r;
  logic                  pred_taken_r;
  logic                  hit_any_r;

  ghbp_pkg::tag_t            tag_r [BUFFER_ENTRIES];
  logic [BUFFER_ENTRIES-1:0] valid_r;

  ghbp_pkg::ctr_t ctr_mem  [COUNTER_ENTRIES];
  ghbp_pkg::tag_t dest_mem [BUFFER_ENTRIES];

  logic            out_valid_r;
  ghbp_pkg::addr_t out_target_r;

  logic              accept;
  logic              is_update;
  ghbp_pkg::addr_t   fall;
  logic              upd_taken;
  ghbp_pkg::ctr_t    ctr_step;
  logic [BIDX_W-1:0] hit_idx;
  logic              hit_any;
  logic [SUM_W-1:0]  idx_sum;
  logic [SUM_W-1:0]  idx_wrap;
  logic [SUM_W-1:0]  idx_mod;
  ghbp_pkg::addr_t   result;

  logic              ctr_we;
  logic [CIDX_W-1:0] ctr_waddr;
  ghbp_pkg::ctr_t    ctr_wdata;
  logic              upd_commit;
  logic              res_load;

  assign accept    = start && !busy;
  assign is_update = (op_r == ghbp_pkg::OP_UPDATE);
  assign fall      = pc_r + ghbp_pkg::FALL_STEP;
  assign upd_taken = (tgt_r != fall);

  // fsm next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ghbp_pkg::S_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = ghbp_pkg::S_IDLE;
      end
      ghbp_pkg::S_IDLE: begin
        if (start) state_nxt = ghbp_pkg::S_LOOK;
      end
      ghbp_pkg::S_LOOK: begin
        state_nxt = is_update ? ghbp_pkg::S_IDLE : ghbp_pkg::S_FETCH;
      end
      ghbp_pkg::S_FETCH: begin
        state_nxt = ghbp_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ghbp_pkg::S_CLEAR;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    busy       = 1'b1;
    ctr_we     = 1'b0;
    ctr_waddr  = idx_r;
    ctr_wdata  = ctr_step;
    upd_commit = 1'b0;
    res_load   = 1'b0;
    case (state_r)
      ghbp_pkg::S_CLEAR: begin
        ctr_we    = 1'b1;
        ctr_waddr = clr_r;
        ctr_wdata = ghbp_pkg::CTR_WEAK_TAKEN;
      end
      ghbp_pkg::S_IDLE: begin
        busy = 1'b0;
      end
      ghbp_pkg::S_LOOK: begin
        ctr_we     = is_update;
        upd_commit = is_update;
      end
      ghbp_pkg::S_FETCH: begin
        res_load = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // saturating step of the counter read for this branch
  always_comb begin
    ctr_step = ctr_rd_r;
    if (upd_taken && ctr_rd_r != ghbp_pkg::CTR_MAX) begin
      ctr_step = ctr_rd_r + ghbp_pkg::CTR_W'(1);
    end else if (!upd_taken && ctr_rd_r != ghbp_pkg::CTR_MIN) begin
      ctr_step = ctr_rd_r - ghbp_pkg::CTR_W'(1);
    end
  end

  // index tracks the 16-bit history modulo the table size
  always_comb begin
    idx_sum  = {1'b0, idx_r, upd_taken};
    idx_wrap = hist_r[ghbp_pkg::HIST_W-1] ? WRAP_S : '0;
    if (idx_sum >= idx_wrap) begin
      idx_mod = idx_sum - idx_wrap;
    end else begin
      idx_mod = idx_sum + ENTRIES_S - idx_wrap;
    end
    if (idx_mod >= ENTRIES_S) idx_mod = idx_mod - ENTRIES_S;
  end

  // the valid tag match is unique, so or-ing indices encodes it
  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < BUFFER_ENTRIES; k++) begin
      if (hit_vec_r[k]) hit_idx = hit_idx | BIDX_W'(k);
    end
  end

  assign hit_any = |hit_vec_r;

  always_comb begin
    clr_nxt  = clr_r;
    idx_nxt  = idx_r;
    hist_nxt = hist_r;
    ptr_nxt  = ptr_r;
    if (state_r == ghbp_pkg::S_CLEAR) clr_nxt = clr_r + CIDX_W'(1);
    if (upd_commit) begin
      idx_nxt  = idx_mod[CIDX_W-1:0];
      hist_nxt = {hist_r[ghbp_pkg::HIST_W-2:0], upd_taken};
      if (upd_taken && !hit_any) ptr_nxt = (ptr_r == PTR_LAST) ? '0 : ptr_r + BIDX_W'(1);
    end
  end

  always_comb begin
    if (!pred_taken_r) begin
      result = fall;
    end else if (hit_any_r && dest_rd_r != '0) begin
      result = {pc_r[ghbp_pkg::PC_W-1:ghbp_pkg::TAG_W], dest_rd_r};
    end else begin
      result = pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ghbp_pkg::S_CLEAR;
      clr_r       <= '0;
      idx_r       <= '0;
      hist_r      <= '0;
      ptr_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      idx_r       <= idx_nxt;
      hist_r      <= hist_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= res_load;
      if (upd_commit && upd_taken && !hit_any) valid_r[ptr_r] <= 1'b1;
    end
  end

  // item and lookup payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      pc_r  <= in_pc;
      tgt_r <= in_actual_target;
      for (int k = 0; k < BUFFER_ENTRIES; k++) begin
        hit_vec_r[k] <= valid_r[k] && (tag_r[k] == in_pc[ghbp_pkg::TAG_W-1:0]);
      end
    end
    if (state_r == ghbp_pkg::S_LOOK) begin
      pred_taken_r <= ctr_rd_r[ghbp_pkg::CTR_W-1];
      hit_any_r    <= hit_any;
    end
    if (res_load) out_target_r <= result;
  end

  always_ff @(posedge clk) begin
    if (upd_commit && upd_taken && !hit_any) tag_r[ptr_r] <= pc_r[ghbp_pkg::TAG_W-1:0];
  end

  // counter memory, read at the current history index
  always_ff @(posedge clk) begin
    if (ctr_we) ctr_mem[ctr_waddr] <= ctr_wdata;
    ctr_rd_r <= ctr_mem[idx_r];
  end

  // destination memory, written at the hit entry or the fifo slot
  always_ff @(posedge clk) begin
    if (upd_commit && upd_taken) begin
      dest_mem[hit_any ? hit_idx : ptr_r] <= tgt_r[ghbp_pkg::TAG_W-1:0];
    end
    dest_rd_r <= dest_mem[hit_idx];
  end

  assign out_valid            = out_valid_r;
  assign out_predicted_target = out_target_r;

endmodule

`default_nettype wire

@@ src/ghbp_checker.sv @@
// port-level checker for the branch predictor core, bound to the core module
// depends on ghbp_pkg and global_history_branch_predictor_core_assert.svh
`default_nettype none

`include "global_history_branch_predictor_core_assert.svh"

module ghbp_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       start,
  input wire                       busy,
  input wire                       in_operation,
  input wire [ghbp_pkg::PC_W-1:0]  in_pc,
  input wire                       out_valid,
  input wire [ghbp_pkg::PC_W-1:0]  out_predicted_target
);

  // a taken predict item yields a word on out_valid
  `GHBP_ASSERT_IMPL(a_predict_gives_word, start && !busy && in_operation == ghbp_pkg::OP_PREDICT, ##3 out_valid)

  // an update never yields a word in the slot a predict would use
  `GHBP_ASSERT_IMPL(a_update_no_word, start && !busy && in_operation == ghbp_pkg::OP_UPDATE, ##3 !out_valid)

  // out_valid is a strobe that drops again after every word it marks
  `GHBP_ASSERT_IMPL(a_strobe_single, out_valid, ##1 !out_valid)

  // the word is pc+4 or keeps the upper pc bits of its item
  `GHBP_ASSERT_IMPL(a_word_from_pc, out_valid, (out_predicted_target == $past(in_pc, 3) + ghbp_pkg::FALL_STEP || out_predicted_target[ghbp_pkg::PC_W-1:ghbp_pkg::TAG_W] == $past(in_pc[ghbp_pkg::PC_W-1:ghbp_pkg::TAG_W], 3)))

endmodule

bind global_history_branch_predictor_core ghbp_checker u_ghbp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .in_operation         (in_operation),
  .in_pc                (in_pc),
  .out_valid            (out_valid),
  .out_predicted_target (out_predicted_target)
);

`default_nettype wire
